// ===== hw/rtl/rwot_pkg.sv =====
// Package with the types, codes and constants of the reader/writer open table.
package rwot_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int KEY_W     = 32;
    localparam int READERS_W = 15;
    localparam int ACTION_W  = 3;
    localparam int STATUS_W  = 3;

    localparam logic [READERS_W-1:0] READERS_MAX = {READERS_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_OPEN_READ   = 3'd0,
        ACT_OPEN_WRITE  = 3'd1,
        ACT_UPGRADE     = 3'd2,
        ACT_DOWNGRADE   = 3'd3,
        ACT_CLOSE_READ  = 3'd4,
        ACT_CLOSE_WRITE = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_WRITER  = 3'd1,
        ST_READERS = 3'd2,
        ST_FULL    = 3'd3,
        ST_NA      = 3'd4,
        ST_SAT     = 3'd5
    } status_t;

    typedef struct packed {
        logic                 valid;
        logic [ACTION_W-1:0]  action;
        logic [KEY_W-1:0]     key;
        logic                 hit;
        logic [READERS_W-1:0] readers;
        logic                 writer;
        logic                 free_found;
    } scan_t;

    typedef struct packed {
        logic                 en;
        logic                 valid;
        logic [KEY_W-1:0]     key;
        logic [READERS_W-1:0] readers;
        logic                 writer;
    } slot_wr_t;

endpackage

// ===== hw/rtl/rwot_cell.sv =====
// One table slot that also forwards the request scan to the next slot.
module rwot_cell
    import rwot_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int INDEX = 0,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  scan_t            scan_in,
    input  logic [IDX_W-1:0] hit_idx_in,
    input  logic [IDX_W-1:0] free_idx_in,
    input  slot_wr_t         wr,
    input  logic [IDX_W-1:0] wr_idx,
    output scan_t            scan_out,
    output logic [IDX_W-1:0] hit_idx_out,
    output logic [IDX_W-1:0] free_idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic                 valid_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [READERS_W-1:0] readers_reg;
    logic                 writer_reg;

    scan_t            scan_reg;
    scan_t            scan_next;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] hit_idx_next;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] free_idx_next;
    logic             wr_here;

    assign wr_here = wr.en && (wr_idx == MY_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_here)
        begin
            valid_reg <= wr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            key_reg     <= wr.key;
            readers_reg <= wr.readers;
            writer_reg  <= wr.writer;
        end
    end

    always_comb
    begin
        scan_next     = scan_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        if (valid_reg && (key_reg == scan_in.key) && !scan_in.hit)
        begin
            scan_next.hit     = 1'b1;
            scan_next.readers = readers_reg;
            scan_next.writer  = writer_reg;
            hit_idx_next      = MY_IDX;
        end
        if (!valid_reg && !scan_in.free_found)
        begin
            scan_next.free_found = 1'b1;
            free_idx_next        = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign scan_out     = scan_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule

// ===== hw/rtl/rwot_ctrl.sv =====
// Decision logic at the end of the chain: slot update, result and busy flag.
module rwot_ctrl
    import rwot_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  scan_t                scan,
    input  logic [IDX_W-1:0]     hit_idx,
    input  logic [IDX_W-1:0]     free_idx,
    output slot_wr_t             wr,
    output logic [IDX_W-1:0]     wr_idx,
    output logic                 busy,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [READERS_W-1:0] reader_count,
    output logic                 write_held
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [READERS_W-1:0] readers_reg;
    logic                 writer_reg;

    status_t              st;
    logic [READERS_W-1:0] out_readers;
    logic                 out_writer;
    logic [READERS_W-1:0] dec_readers;

    always_comb
    begin
        st          = ST_NA;
        out_readers = scan.hit ? scan.readers : '0;
        out_writer  = scan.hit ? scan.writer : 1'b0;
        dec_readers = (scan.readers != '0) ? scan.readers - READERS_W'(1) : scan.readers;
        wr          = '0;
        wr.key      = scan.key;
        wr_idx      = hit_idx;
        case (action_t'(scan.action))
            ACT_OPEN_READ:
            begin
                if (!scan.hit)
                begin
                    if (scan.free_found)
                    begin
                        st          = ST_OK;
                        wr.en       = 1'b1;
                        wr.valid    = 1'b1;
                        wr.readers  = READERS_W'(1);
                        wr_idx      = free_idx;
                        out_readers = READERS_W'(1);
                    end
                    else
                    begin
                        st = ST_FULL;
                    end
                end
                else if (scan.writer)
                begin
                    st = ST_WRITER;
                end
                else if (scan.readers == READERS_MAX)
                begin
                    st = ST_SAT;
                end
                else
                begin
                    st          = ST_OK;
                    wr.en       = 1'b1;
                    wr.valid    = 1'b1;
                    wr.readers  = scan.readers + READERS_W'(1);
                    out_readers = wr.readers;
                end
            end
            ACT_OPEN_WRITE:
            begin
                if (!scan.hit)
                begin
                    if (scan.free_found)
                    begin
                        st         = ST_OK;
                        wr.en      = 1'b1;
                        wr.valid   = 1'b1;
                        wr.writer  = 1'b1;
                        wr_idx     = free_idx;
                        out_writer = 1'b1;
                    end
                    else
                    begin
                        st = ST_FULL;
                    end
                end
                else
                begin
                    st = scan.writer ? ST_WRITER : ST_READERS;
                end
            end
            ACT_UPGRADE:
            begin
                if (!scan.hit)
                begin
                    st = ST_NA;
                end
                else if (scan.writer)
                begin
                    st = ST_WRITER;
                end
                else if (scan.readers != READERS_W'(1))
                begin
                    st = ST_READERS;
                end
                else
                begin
                    st          = ST_OK;
                    wr.en       = 1'b1;
                    wr.valid    = 1'b1;
                    wr.writer   = 1'b1;
                    out_readers = '0;
                    out_writer  = 1'b1;
                end
            end
            ACT_DOWNGRADE:
            begin
                if (!scan.hit)
                begin
                    st = ST_NA;
                end
                else if (!scan.writer)
                begin
                    st = ST_READERS;
                end
                else
                begin
                    st          = ST_OK;
                    wr.en       = 1'b1;
                    wr.valid    = 1'b1;
                    wr.readers  = READERS_W'(1);
                    out_readers = READERS_W'(1);
                    out_writer  = 1'b0;
                end
            end
            ACT_CLOSE_READ:
            begin
                if (!scan.hit)
                begin
                    st = ST_NA;
                end
                else if (scan.writer)
                begin
                    st = ST_WRITER;
                end
                else
                begin
                    st          = ST_OK;
                    wr.en       = 1'b1;
                    wr.valid    = (dec_readers != '0);
                    wr.readers  = dec_readers;
                    out_readers = dec_readers;
                    out_writer  = 1'b0;
                end
            end
            ACT_CLOSE_WRITE:
            begin
                if (!scan.hit)
                begin
                    st = ST_NA;
                end
                else if (!scan.writer)
                begin
                    st = ST_READERS;
                end
                else
                begin
                    st          = ST_OK;
                    wr.en       = 1'b1;
                    wr.valid    = 1'b0;
                    out_readers = '0;
                    out_writer  = 1'b0;
                end
            end
            default:
            begin
                st = ST_NA;
            end
        endcase
        wr.en = wr.en && scan.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= scan.valid;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (scan.valid)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan.valid)
        begin
            status_reg  <= st;
            readers_reg <= out_readers;
            writer_reg  <= out_writer;
        end
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign status       = status_reg;
    assign reader_count = readers_reg;
    assign write_held   = writer_reg;

endmodule

// ===== hw/rtl/reader_writer_open_table.sv =====
// Top level of the reader/writer open table: a chain of slot cells and the end controller.
//
//  Channel   Signals                               Transfer
//  request   start, busy, action, entry_key        edge with start high and busy low
//  result    done, status, reader_count, write_held edge ending the cycle done is high
//
//  A request scans the slot chain one cell per cycle, each cell registering the scan, and the
//  controller registers the result strobe; busy stays high until the result is shown, and
//  a new request may be taken in the cycle the result is shown.
//  Reset clears every slot's valid flag and the scan; no clearing pass is needed.
//  The receiver cannot stall; results are shown for a single cycle.
module reader_writer_open_table
    import rwot_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ACTION_W-1:0]  action,
    input  logic [KEY_W-1:0]     entry_key,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [READERS_W-1:0] reader_count,
    output logic                 write_held
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    scan_t            scan_chain     [SLOTS+1];
    logic [IDX_W-1:0] hit_idx_chain  [SLOTS+1];
    logic [IDX_W-1:0] free_idx_chain [SLOTS+1];
    slot_wr_t         wr;
    logic [IDX_W-1:0] wr_idx;
    logic             accept;

    assign accept = start && !busy;

    always_comb
    begin
        scan_chain[0]        = '0;
        scan_chain[0].valid  = accept;
        scan_chain[0].action = action;
        scan_chain[0].key    = entry_key;
        hit_idx_chain[0]     = '0;
        free_idx_chain[0]    = '0;
    end

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        rwot_cell #(
            .SLOTS (SLOTS),
            .INDEX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .scan_in      (scan_chain[i]),
            .hit_idx_in   (hit_idx_chain[i]),
            .free_idx_in  (free_idx_chain[i]),
            .wr           (wr),
            .wr_idx       (wr_idx),
            .scan_out     (scan_chain[i+1]),
            .hit_idx_out  (hit_idx_chain[i+1]),
            .free_idx_out (free_idx_chain[i+1])
        );
    end

    rwot_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .scan         (scan_chain[SLOTS]),
        .hit_idx      (hit_idx_chain[SLOTS]),
        .free_idx     (free_idx_chain[SLOTS]),
        .wr           (wr),
        .wr_idx       (wr_idx),
        .busy         (busy),
        .done         (done),
        .status       (status),
        .reader_count (reader_count),
        .write_held   (write_held)
    );

endmodule

// ===== tb/lock_check_pkg.sv =====
// Scoreboard class that predicts and checks the lock state of the reader/writer open table.
package lock_check_pkg;

    import rwot_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [READERS_W-1:0] readers;
        logic                 writer;
    } lock_state_t;

    class lock_scoreboard;

        bit                   held[SLOTS_DEF];
        logic [KEY_W-1:0]     keys[SLOTS_DEF];
        logic [READERS_W-1:0] readers[SLOTS_DEF];
        bit                   writer[SLOTS_DEF];
        lock_state_t          expected_locks[$];
        int unsigned          mismatches;

        function new();
            foreach (held[i])
            begin
                held[i]    = 1'b0;
                keys[i]    = '0;
                readers[i] = '0;
                writer[i]  = 1'b0;
            end
            mismatches = 0;
        endfunction

        function int slot_of(logic [KEY_W-1:0] key);
            foreach (held[i])
            begin
                if (held[i] && keys[i] == key)
                    return i;
            end
            return -1;
        endfunction

        function status_t claim(logic [KEY_W-1:0] key, bit as_writer);
            int f;
            f = -1;
            foreach (held[i])
            begin
                if (!held[i] && f < 0)
                    f = i;
            end
            if (f < 0)
                return ST_FULL;
            held[f]    = 1'b1;
            keys[f]    = key;
            readers[f] = as_writer ? READERS_W'(0) : READERS_W'(1);
            writer[f]  = as_writer;
            return ST_OK;
        endfunction

        function bit pick_held(output logic [KEY_W-1:0] key);
            int live[$];
            key = '0;
            foreach (held[i])
            begin
                if (held[i])
                    live.push_back(i);
            end
            if (live.size() == 0)
                return 1'b0;
            key = keys[live[$urandom_range(live.size() - 1)]];
            return 1'b1;
        endfunction

        function void note_request(logic [ACTION_W-1:0] action, logic [KEY_W-1:0] key);
            int          s;
            status_t     st;
            lock_state_t res;
            s  = slot_of(key);
            st = ST_NA;
            case (action)
                ACT_OPEN_READ:
                    if (s < 0)
                        st = claim(key, 1'b0);
                    else if (writer[s])
                        st = ST_WRITER;
                    else if (readers[s] == READERS_MAX)
                        st = ST_SAT;
                    else
                    begin
                        readers[s] = readers[s] + 1'b1;
                        st = ST_OK;
                    end
                ACT_OPEN_WRITE:
                    if (s < 0)
                        st = claim(key, 1'b1);
                    else
                        st = writer[s] ? ST_WRITER : ST_READERS;
                ACT_UPGRADE:
                    if (s < 0)
                        st = ST_NA;
                    else if (writer[s])
                        st = ST_WRITER;
                    else if (readers[s] != READERS_W'(1))
                        st = ST_READERS;
                    else
                    begin
                        readers[s] = '0;
                        writer[s]  = 1'b1;
                        st = ST_OK;
                    end
                ACT_DOWNGRADE:
                    if (s < 0)
                        st = ST_NA;
                    else if (!writer[s])
                        st = ST_READERS;
                    else
                    begin
                        writer[s]  = 1'b0;
                        readers[s] = READERS_W'(1);
                        st = ST_OK;
                    end
                ACT_CLOSE_READ:
                    if (s < 0)
                        st = ST_NA;
                    else if (writer[s])
                        st = ST_WRITER;
                    else
                    begin
                        if (readers[s] != '0)
                            readers[s] = readers[s] - 1'b1;
                        if (readers[s] == '0)
                            held[s] = 1'b0;
                        st = ST_OK;
                    end
                ACT_CLOSE_WRITE:
                    if (s < 0)
                        st = ST_NA;
                    else if (!writer[s])
                        st = ST_READERS;
                    else
                    begin
                        held[s] = 1'b0;
                        st = ST_OK;
                    end
                default:
                    st = ST_NA;
            endcase
            s = slot_of(key);
            res.status  = st;
            res.readers = (s < 0) ? '0 : readers[s];
            res.writer  = (s < 0) ? 1'b0 : writer[s];
            expected_locks.push_back(res);
        endfunction

        function void check_result(logic [STATUS_W-1:0] got_status,
                                   logic [READERS_W-1:0] got_readers, logic got_writer);
            lock_state_t exp;
            if (expected_locks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: unexpected result status %0d readers %0d writer %0d",
                             $realtime, got_status, got_readers, got_writer);
                return;
            end
            exp = expected_locks.pop_front();
            if (exp.status !== got_status || exp.readers !== got_readers ||
                exp.writer !== got_writer)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: mismatch status %0d/%0d readers %0d/%0d writer %0d/%0d %s",
                             $realtime, exp.status, got_status, exp.readers, got_readers,
                             exp.writer, got_writer, "(expected/actual)");
            end
        endfunction

    endclass

endpackage

// ===== tb/testbench.sv =====
// Top-level testbench of the reader/writer open table: clock, reset, request driver and checks.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rwot_pkg::*;
    import lock_check_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
    localparam int                  RANDOM_ITEMS = 800;
    localparam int                  POOL_SIZE    = 20;
    localparam int                  READER_PILE  = 8;
    localparam int                  DRAIN_CYCLES = 2 * SLOTS_DEF + 4;
    localparam logic [KEY_W-1:0]    KEY_LOW      = 32'h0000_0000;
    localparam logic [KEY_W-1:0]    KEY_HIGH     = 32'hFFFF_FFFF;
    localparam logic [KEY_W-1:0]    KEY_BUSY     = 32'hA5A5_5A5A;
    localparam logic [KEY_W-1:0]    KEY_FILL     = 32'h0000_0100;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [ACTION_W-1:0]  action;
    logic [KEY_W-1:0]     entry_key;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [READERS_W-1:0] reader_count;
    logic                 write_held;

    int unsigned          idle_pct;
    logic [KEY_W-1:0]     key_pool[POOL_SIZE];
    lock_scoreboard       locks = new();

    reader_writer_open_table u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .entry_key    (entry_key),
        .done         (done),
        .status       (status),
        .reader_count (reader_count),
        .write_held   (write_held)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            locks.check_result(status, reader_count, write_held);
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key);
        bit taken;
        taken     = 1'b0;
        action    = act;
        entry_key = key;
        while (!taken)
        begin
            start = ($urandom_range(99) >= idle_pct);
            @(posedge clk);
            taken = start && !busy;
            if (taken)
                locks.note_request(act, key);
            @(negedge clk);
        end
    endtask

    task automatic random_request();
        int unsigned         pick;
        logic [ACTION_W-1:0] act;
        logic [KEY_W-1:0]    key;
        logic [KEY_W-1:0]    live_key;
        pick = $urandom_range(99);
        if (pick < 30)
            act = ACT_OPEN_READ;
        else if (pick < 48)
            act = ACT_OPEN_WRITE;
        else if (pick < 58)
            act = ACT_UPGRADE;
        else if (pick < 66)
            act = ACT_DOWNGRADE;
        else if (pick < 82)
            act = ACT_CLOSE_READ;
        else if (pick < 96)
            act = ACT_CLOSE_WRITE;
        else if (pick < 98)
            act = ACT_SPARE_6;
        else
            act = ACT_SPARE_7;
        key = key_pool[$urandom_range(POOL_SIZE - 1)];
        if ($urandom_range(99) < 10)
            key = $urandom;
        else if (act != ACT_OPEN_READ && act != ACT_OPEN_WRITE && $urandom_range(99) < 60)
        begin
            if (locks.pick_held(live_key))
                key = live_key;
        end
        send(act, key);
    endtask

    initial
    begin
        int n;
        start     = 1'b0;
        action    = ACT_OPEN_READ;
        entry_key = '0;
        rst_n     = 1'b0;
        idle_pct  = 0;
        key_pool[0] = KEY_LOW;
        key_pool[1] = KEY_HIGH;
        for (n = 2; n < POOL_SIZE; n++)
            key_pool[n] = $urandom;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Actions on an absent key and the unused action codes change nothing.
        send(ACT_CLOSE_READ, KEY_LOW);
        send(ACT_UPGRADE, KEY_LOW);
        send(ACT_DOWNGRADE, KEY_LOW);
        send(ACT_CLOSE_WRITE, KEY_LOW);
        send(ACT_SPARE_6, KEY_LOW);
        send(ACT_SPARE_7, KEY_HIGH);

        send(ACT_OPEN_READ, KEY_LOW);
        send(ACT_OPEN_WRITE, KEY_LOW);
        send(ACT_OPEN_READ, KEY_LOW);
        send(ACT_UPGRADE, KEY_LOW);
        send(ACT_DOWNGRADE, KEY_LOW);
        send(ACT_CLOSE_WRITE, KEY_LOW);
        send(ACT_CLOSE_READ, KEY_LOW);
        send(ACT_UPGRADE, KEY_LOW);
        send(ACT_OPEN_READ, KEY_LOW);
        send(ACT_OPEN_WRITE, KEY_LOW);
        send(ACT_UPGRADE, KEY_LOW);
        send(ACT_CLOSE_READ, KEY_LOW);
        send(ACT_DOWNGRADE, KEY_LOW);
        send(ACT_CLOSE_READ, KEY_LOW);
        send(ACT_OPEN_WRITE, KEY_HIGH);
        send(ACT_CLOSE_WRITE, KEY_HIGH);

        // Fill every slot, then try to open one more key for writing and another for reading.
        for (n = 0; n <= SLOTS_DEF; n++)
            send(ACT_OPEN_WRITE, KEY_FILL + n);
        send(ACT_OPEN_READ, KEY_HIGH);
        for (n = 0; n < SLOTS_DEF; n++)
            send(ACT_CLOSE_WRITE, KEY_FILL + n);

        // Stack several readers on one key.
        for (n = 0; n < READER_PILE; n++)
            send(ACT_OPEN_READ, KEY_BUSY);
        send(ACT_OPEN_WRITE, KEY_BUSY);
        send(ACT_CLOSE_READ, KEY_BUSY);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n < RANDOM_ITEMS / 3)
                idle_pct = 10;
            else if (n < 2 * RANDOM_ITEMS / 3)
                idle_pct = 64;
            else
                idle_pct = 0;
            random_request();
        end
        start = 1'b0;

        while (locks.expected_locks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (locks.mismatches == 0 && locks.expected_locks.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rwot_pkg.sv
hw/rtl/rwot_cell.sv
hw/rtl/rwot_ctrl.sv
hw/rtl/reader_writer_open_table.sv
tb/lock_check_pkg.sv
tb/testbench.sv
